// ===== rtl/s5rc_pkg.sv =====
// ----------------------------------------------------------------------------
// SOCKS5 client reply checker package
// Shared types, protocol constants and result codes.
// ----------------------------------------------------------------------------
package s5rc_pkg;

  localparam logic [7:0] SOCKS_VERSION   = 8'h05;
  localparam logic [7:0] AUTH_VERSION    = 8'h01;
  localparam logic [7:0] METHOD_NONE     = 8'h00;
  localparam logic [7:0] METHOD_USERPASS = 8'h02;
  localparam logic [7:0] AUTH_OK         = 8'h00;
  localparam logic [7:0] REP_SUCCEEDED   = 8'h00;
  localparam logic [7:0] RSV_VALUE       = 8'h00;
  localparam logic [7:0] ATYP_IPV4       = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN     = 8'h03;
  localparam logic [7:0] ATYP_IPV6       = 8'h04;

  localparam int IPV4_ADDR_LEN = 4;
  localparam int IPV6_ADDR_LEN = 16;
  localparam int PORT_LEN      = 2;
  localparam int SKIP_W        = 9;

  localparam logic [SKIP_W-1:0] SKIP_IPV4 = SKIP_W'(IPV4_ADDR_LEN + PORT_LEN);
  localparam logic [SKIP_W-1:0] SKIP_IPV6 = SKIP_W'(IPV6_ADDR_LEN + PORT_LEN);
  localparam logic [SKIP_W-1:0] SKIP_PORT = SKIP_W'(PORT_LEN);

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [1:0] ST_PROGRESS  = 2'd0;
  localparam logic [1:0] ST_CONNECTED = 2'd1;
  localparam logic [1:0] ST_FAILED    = 2'd2;

  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_GREET_VER   = 4'd1;
  localparam logic [3:0] ERR_METHOD      = 4'd2;
  localparam logic [3:0] ERR_AUTH        = 4'd3;
  localparam logic [3:0] ERR_REPLY_VER   = 4'd4;
  localparam logic [3:0] ERR_REFUSED     = 4'd5;
  localparam logic [3:0] ERR_RESERVED    = 4'd6;
  localparam logic [3:0] ERR_ADDR_TYPE   = 4'd7;
  localparam logic [3:0] ERR_AFTER_END   = 4'd8;

  localparam logic [1:0] SEND_NOTHING = 2'd0;
  localparam logic [1:0] SEND_AUTH    = 2'd1;
  localparam logic [1:0] SEND_CONNECT = 2'd2;

  typedef enum logic [2:0] {
    PH_GREET  = 3'd0,
    PH_AUTH   = 3'd1,
    PH_REPLY  = 3'd2,
    PH_DOMLEN = 3'd3,
    PH_SKIP   = 3'd4,
    PH_DONE   = 3'd5,
    PH_FAILED = 3'd6
  } phase_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] error_code;
    logic [1:0] send_next;
    logic [7:0] reply_code;
  } result_t;

endpackage

// ===== rtl/s5rc_ifs.sv =====
// ----------------------------------------------------------------------------
// SOCKS5 client reply checker channels
// Valid/ready channels for received bytes, results and configuration.
// ----------------------------------------------------------------------------
interface s5rc_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

interface s5rc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] error_code;
  logic [1:0] send_next;
  logic [7:0] reply_code;

  modport source (output valid, output status, output error_code, output send_next,
                  output reply_code, input ready);
  modport sink (input valid, input status, input error_code, input send_next,
                input reply_code, output ready);
endinterface

interface s5rc_cfg_if;
  logic valid;
  logic ready;
  logic creds_offered;

  modport source (output valid, output creds_offered, input ready);
  modport sink (input valid, input creds_offered, output ready);
endinterface

// ===== rtl/s5rc_in_stage.sv =====
// ----------------------------------------------------------------------------
// SOCKS5 client reply checker input stage
// Registers one accepted request and holds it while the result side stalls.
// ----------------------------------------------------------------------------
module s5rc_in_stage
  import s5rc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  in_ready,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r;
  item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== rtl/s5rc_fsm.sv =====
// ----------------------------------------------------------------------------
// SOCKS5 client reply checker phase logic
// Tracks the handshake phase and checks each received byte in one pass.
// ----------------------------------------------------------------------------
module s5rc_fsm
  import s5rc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  input  logic    creds_offered,
  output result_t result
);

  phase_t            phase_r, phase_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic [7:0]        held_r [3];
  logic [7:0]        held_nxt [3];
  logic [SKIP_W-1:0] skip_r, skip_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_GREET;
      idx_r   <= 2'd0;
      skip_r  <= '0;
      for (int i = 0; i < 3; i++) begin
        held_r[i] <= 8'h00;
      end
    end else if (step) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      skip_r  <= skip_nxt;
      for (int i = 0; i < 3; i++) begin
        held_r[i] <= held_nxt[i];
      end
    end
  end

  always_comb begin
    logic [7:0]        b;
    logic [SKIP_W-1:0] skip_dec;
    b         = item.rx_byte;
    skip_dec  = skip_r - SKIP_W'(1);
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    skip_nxt  = skip_r;
    for (int i = 0; i < 3; i++) begin
      held_nxt[i] = held_r[i];
    end
    result = '{status: ST_PROGRESS, error_code: ERR_NONE,
               send_next: SEND_NOTHING, reply_code: 8'h00};

    if (item.operation == OP_RESTART) begin
      phase_nxt = PH_GREET;
      idx_nxt   = 2'd0;
      skip_nxt  = '0;
      for (int i = 0; i < 3; i++) begin
        held_nxt[i] = 8'h00;
      end
    end else begin
      unique case (phase_r)
        PH_GREET: begin
          if (idx_r == 2'd0) begin
            held_nxt[0] = b;
            idx_nxt     = 2'd1;
          end else begin
            idx_nxt = 2'd0;
            if (held_r[0] != SOCKS_VERSION) begin
              result.error_code = ERR_GREET_VER;
            end else if (b == METHOD_USERPASS && creds_offered) begin
              result.send_next = SEND_AUTH;
              phase_nxt        = PH_AUTH;
            end else if (b == METHOD_NONE) begin
              result.send_next = SEND_CONNECT;
              phase_nxt        = PH_REPLY;
            end else begin
              result.error_code = ERR_METHOD;
            end
          end
        end
        PH_AUTH: begin
          if (idx_r == 2'd0) begin
            held_nxt[0] = b;
            idx_nxt     = 2'd1;
          end else begin
            idx_nxt = 2'd0;
            if (held_r[0] != AUTH_VERSION || b != AUTH_OK) begin
              result.error_code = ERR_AUTH;
            end else begin
              result.send_next = SEND_CONNECT;
              phase_nxt        = PH_REPLY;
            end
          end
        end
        PH_REPLY: begin
          if (idx_r != 2'd3) begin
            held_nxt[idx_r] = b;
            idx_nxt         = idx_r + 2'd1;
          end else begin
            idx_nxt           = 2'd0;
            result.reply_code = held_r[1];
            if (held_r[0] != SOCKS_VERSION) begin
              result.error_code = ERR_REPLY_VER;
            end else if (held_r[1] != REP_SUCCEEDED) begin
              result.error_code = ERR_REFUSED;
            end else if (held_r[2] != RSV_VALUE) begin
              result.error_code = ERR_RESERVED;
            end else if (b == ATYP_IPV4) begin
              skip_nxt  = SKIP_IPV4;
              phase_nxt = PH_SKIP;
            end else if (b == ATYP_IPV6) begin
              skip_nxt  = SKIP_IPV6;
              phase_nxt = PH_SKIP;
            end else if (b == ATYP_DOMAIN) begin
              phase_nxt = PH_DOMLEN;
            end else begin
              result.error_code = ERR_ADDR_TYPE;
            end
          end
        end
        PH_DOMLEN: begin
          skip_nxt  = {1'b0, b} + SKIP_PORT;
          phase_nxt = PH_SKIP;
        end
        PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            result.status = ST_CONNECTED;
            phase_nxt     = PH_DONE;
          end
        end
        PH_DONE, PH_FAILED: begin
          result.error_code = ERR_AFTER_END;
        end
        default: begin
          result.error_code = ERR_AFTER_END;
        end
      endcase

      if (result.error_code != ERR_NONE) begin
        result.status = ST_FAILED;
        phase_nxt     = PH_FAILED;
        idx_nxt       = 2'd0;
      end
    end
  end

endmodule

// ===== rtl/s5rc_out_stage.sv =====
// ----------------------------------------------------------------------------
// SOCKS5 client reply checker output stage
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module s5rc_out_stage
  import s5rc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_valid,
  input  result_t res,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid_r;
  result_t res_r;

  assign advance   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// ===== rtl/socks5_client_reply_checker.sv =====
// Path: input register, combinational check, then the result register.
// Throughput: one request per cycle; the input register and the result
// register each take a new entry whenever the result register drains.
// Reset: synchronous on rst_n low; phase returns to awaiting the method
// reply, counters and held bytes clear, creds_offered clears to 0.
// ----------------------------------------------------------------------------
// SOCKS5 client reply checker
// Checks the proxy's method, authentication and connect replies byte by byte.
// ----------------------------------------------------------------------------
module socks5_client_reply_checker
  import s5rc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  s5rc_in_if.sink      in_chan,
  s5rc_out_if.source   out_chan,
  s5rc_cfg_if.sink     cfg_chan
);

  logic    creds_r;
  logic    advance;
  logic    item_valid;
  item_t   in_item;
  item_t   item;
  result_t res;
  result_t out_res;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      creds_r <= 1'b0;
    end else if (cfg_chan.valid) begin
      creds_r <= cfg_chan.creds_offered;
    end
  end

  assign in_item = '{operation: in_chan.operation, rx_byte: in_chan.rx_byte};

  s5rc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_item    (in_item),
    .in_ready   (in_chan.ready),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  s5rc_fsm u_fsm (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (item_valid && advance),
    .item          (item),
    .creds_offered (creds_r),
    .result        (res)
  );

  s5rc_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (item_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  assign out_chan.status     = out_res.status;
  assign out_chan.error_code = out_res.error_code;
  assign out_chan.send_next  = out_res.send_next;
  assign out_chan.reply_code = out_res.reply_code;

endmodule

// ===== rtl/s5rc_checker.sv =====
// ----------------------------------------------------------------------------
// SOCKS5 client reply checker assertions
// Port-level checks on result consistency and reset, bound to the top level.
// ----------------------------------------------------------------------------
module s5rc_checker
  import s5rc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [3:0] error_code,
  input logic [1:0] send_next,
  input logic [7:0] reply_code
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_fail_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((status == ST_FAILED) == (error_code != ERR_NONE)))
    else $error("failed status and error code disagree");

  a_connected_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status == ST_CONNECTED) |->
      (send_next == SEND_NOTHING && reply_code == 8'h00))
    else $error("connected result carries extra fields");

  a_reply_code_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && reply_code != 8'h00) |->
      (error_code == ERR_REPLY_VER || error_code == ERR_REFUSED))
    else $error("nonzero reply code without a reply error");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(error_code)))
    else $error("stalled result changed");

endmodule

bind socks5_client_reply_checker s5rc_checker u_s5rc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .status     (out_chan.status),
  .error_code (out_chan.error_code),
  .send_next  (out_chan.send_next),
  .reply_code (out_chan.reply_code)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// SOCKS5 client reply checker testbench
// Feeds proxy reply bytes and restarts through the valid/ready channels and
// checks every verdict against an in-bench model of the handshake. A short
// directed sequence covers the check order, the refusal paths and an empty
// domain name. Random handshakes follow, mostly well formed with corrupted
// fields, truncations and noise mixed in, while both sides stall at random.
// The run alternates the offered-credentials setting between phases.
// ----------------------------------------------------------------------------
module testbench
  import s5rc_pkg::*;
;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 310;
  localparam int RANDOM_PHASES = 5;

  class handshake_scoreboard;
    bit         creds;
    phase_t     phase;
    logic [2:0] idx;
    logic [7:0] held [3];
    logic [8:0] skip_left;
    result_t    pending_verdicts [$];
    int         faults;
    int         checked;
    int         connects;
    int         refusals;

    function new();
      creds = 1'b0;
      faults = 0;
      checked = 0;
      connects = 0;
      refusals = 0;
      clear_progress();
    endfunction

    function void clear_progress();
      phase = PH_GREET;
      idx = '0;
      held[0] = '0;
      held[1] = '0;
      held[2] = '0;
      skip_left = '0;
    endfunction

    function void set_creds(bit v);
      creds = v;
    endfunction

    function result_t predict_verdict(item_t it);
      result_t    r;
      logic [3:0] err;
      logic [7:0] b;
      r = '0;
      err = ERR_NONE;
      b = it.rx_byte;
      if (it.operation == OP_RESTART) begin
        clear_progress();
      end else begin
        case (phase)
          PH_GREET: begin
            if (idx == 3'd0) begin
              held[0] = b;
              idx = 3'd1;
            end else begin
              idx = 3'd0;
              if (held[0] != SOCKS_VERSION) begin
                err = ERR_GREET_VER;
              end else if (b == METHOD_USERPASS && creds) begin
                r.send_next = SEND_AUTH;
                phase = PH_AUTH;
              end else if (b == METHOD_NONE) begin
                r.send_next = SEND_CONNECT;
                phase = PH_REPLY;
              end else begin
                err = ERR_METHOD;
              end
            end
          end
          PH_AUTH: begin
            if (idx == 3'd0) begin
              held[0] = b;
              idx = 3'd1;
            end else begin
              idx = 3'd0;
              if (held[0] != AUTH_VERSION || b != AUTH_OK) begin
                err = ERR_AUTH;
              end else begin
                r.send_next = SEND_CONNECT;
                phase = PH_REPLY;
              end
            end
          end
          PH_REPLY: begin
            if (idx < 3'd3) begin
              held[idx] = b;
              idx = idx + 3'd1;
            end else begin
              idx = 3'd0;
              r.reply_code = held[1];
              if (held[0] != SOCKS_VERSION) begin
                err = ERR_REPLY_VER;
              end else if (held[1] != REP_SUCCEEDED) begin
                err = ERR_REFUSED;
              end else if (held[2] != RSV_VALUE) begin
                err = ERR_RESERVED;
              end else if (b == ATYP_IPV4) begin
                skip_left = SKIP_IPV4;
                phase = PH_SKIP;
              end else if (b == ATYP_IPV6) begin
                skip_left = SKIP_IPV6;
                phase = PH_SKIP;
              end else if (b == ATYP_DOMAIN) begin
                phase = PH_DOMLEN;
              end else begin
                err = ERR_ADDR_TYPE;
              end
            end
          end
          PH_DOMLEN: begin
            skip_left = SKIP_W'(b) + SKIP_PORT;
            phase = PH_SKIP;
          end
          PH_SKIP: begin
            skip_left = skip_left - 1'b1;
            if (skip_left == '0) begin
              r.status = ST_CONNECTED;
              phase = PH_DONE;
            end
          end
          default: begin
            err = ERR_AFTER_END;
          end
        endcase
        if (err != ERR_NONE) begin
          r.status = ST_FAILED;
          r.error_code = err;
          phase = PH_FAILED;
          idx = 3'd0;
        end
      end
      return r;
    endfunction

    function void note_request(item_t it);
      result_t r;
      r = predict_verdict(it);
      pending_verdicts = {pending_verdicts, r};
    endfunction

    function void check_verdict(result_t got);
      result_t want;
      checked++;
      if (pending_verdicts.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected result: status %0d error %0d send %0d reply %02h",
                   got.status, got.error_code, got.send_next, got.reply_code);
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.status == ST_CONNECTED) connects++;
      if (got.status == ST_FAILED) refusals++;
      if (got.status != want.status || got.error_code != want.error_code ||
          got.send_next != want.send_next || got.reply_code != want.reply_code) begin
        faults++;
        if (faults <= 10)
          $display("mismatch: expected %0d/%0d/%0d/%02h, got %0d/%0d/%0d/%02h",
                   want.status, want.error_code, want.send_next, want.reply_code,
                   got.status, got.error_code, got.send_next, got.reply_code);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  s5rc_in_if  in_chan ();
  s5rc_out_if out_chan ();
  s5rc_cfg_if cfg_chan ();

  socks5_client_reply_checker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  handshake_scoreboard sb = new();

  bit          steady = 1'b0;
  int unsigned stretch_left = 0;
  int unsigned cycles = 0;
  int          accepted = 0;
  int          settings = 0;
  bit          creds_now = 1'b0;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stretch_left == 0) begin
      steady <= ($urandom_range(0, 3) == 0);
      stretch_left <= $urandom_range(20, 200);
    end else begin
      stretch_left <= stretch_left - 1;
    end
  end

  always @(posedge clk) begin : watch_results
    result_t got;
    got = {out_chan.status, out_chan.error_code, out_chan.send_next, out_chan.reply_code};
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_verdict(got);
  end

  initial begin : result_sink
    int n;
    forever begin
      n = steady ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        out_chan.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(out_chan.valid && out_chan.ready));
    end
  end

  task automatic send_item(logic op, logic [7:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.operation <= op;
    in_chan.rx_byte <= b;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_request({op, b});
    accepted++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(OP_BYTE, b);
  endtask

  task automatic send_restart(logic [7:0] filler);
    send_item(OP_RESTART, filler);
  endtask

  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_creds(bit v);
    cfg_chan.valid <= 1'b1;
    cfg_chan.creds_offered <= v;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    sb.set_creds(v);
    creds_now = v;
    settings++;
  endtask

  function automatic logic [7:0] mostly(logic [7:0] good, int odds);
    if ($urandom_range(0, odds - 1) == 0) return 8'($urandom_range(0, 255));
    return good;
  endfunction

  task automatic run_handshake();
    logic [7:0] seq [$];
    logic [7:0] m;
    logic [7:0] atyp;
    int         len;
    int         r;
    int         cut;
    if ($urandom_range(0, 14) == 0) begin
      repeat ($urandom_range(1, 6))
        send_item(($urandom_range(0, 3) == 0) ? OP_RESTART : OP_BYTE,
                  8'($urandom_range(0, 255)));
      return;
    end
    seq = {seq, mostly(SOCKS_VERSION, 20)};
    m = (creds_now && $urandom_range(0, 2) != 0) ? METHOD_USERPASS : METHOD_NONE;
    seq = {seq, mostly(m, 10)};
    if (m == METHOD_USERPASS) begin
      seq = {seq, mostly(AUTH_VERSION, 15)};
      seq = {seq, mostly(AUTH_OK, 15)};
    end
    seq = {seq, mostly(SOCKS_VERSION, 20)};
    seq = {seq, mostly(REP_SUCCEEDED, 6)};
    seq = {seq, mostly(RSV_VALUE, 20)};
    case ($urandom_range(0, 2))
      0: begin atyp = ATYP_IPV4; len = IPV4_ADDR_LEN; end
      1: begin atyp = ATYP_IPV6; len = IPV6_ADDR_LEN; end
      default: begin
        atyp = ATYP_DOMAIN;
        r = $urandom_range(0, 39);
        len = (r == 0) ? 255 : (r <= 5) ? 0 : $urandom_range(1, 12);
      end
    endcase
    seq = {seq, mostly(atyp, 15)};
    if (atyp == ATYP_DOMAIN) seq = {seq, 8'(len)};
    repeat (len + PORT_LEN) seq = {seq, 8'($urandom_range(0, 255))};
    if ($urandom_range(0, 4) == 0) seq = {seq, 8'($urandom_range(0, 255))};
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, seq.size()) : seq.size();
    if ($urandom_range(0, 9) != 0) send_restart(8'($urandom_range(0, 255)));
    for (int i = 0; i < cut; i++) begin
      send_byte(seq[i]);
      if (sb.phase == PH_FAILED && i + 1 < cut) begin
        if ($urandom_range(0, 2) == 0) send_byte(8'($urandom_range(0, 255)));
        break;
      end
    end
  endtask

  initial begin : stimulus
    int target;
    in_chan.valid <= 1'b0;
    in_chan.operation <= OP_BYTE;
    in_chan.rx_byte <= 8'h00;
    cfg_chan.valid <= 1'b0;
    cfg_chan.creds_offered <= 1'b0;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    write_creds(1'b0);

    send_restart(8'hA5);
    send_byte(8'hFF);
    send_byte(METHOD_USERPASS);
    send_byte(8'h00);
    send_restart(8'h5A);
    send_byte(SOCKS_VERSION);
    send_byte(METHOD_USERPASS);
    send_restart(8'hFF);
    send_byte(SOCKS_VERSION);
    send_byte(METHOD_NONE);
    send_byte(SOCKS_VERSION);
    send_byte(REP_SUCCEEDED);
    send_byte(RSV_VALUE);
    send_byte(ATYP_DOMAIN);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h7E);
    send_restart(8'h00);
    send_byte(SOCKS_VERSION);
    send_byte(METHOD_NONE);
    send_byte(8'h04);
    send_byte(8'h01);
    send_byte(8'h01);
    send_byte(8'h09);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      write_creds(p % 2 == 0);
      target = accepted + PHASE_ITEMS;
      while (accepted < target) run_handshake();
    end

    wait_idle();
    repeat (4) @(posedge clk);
    $display("Covered %0d requests and %0d results over %0d register settings.",
             accepted, sb.checked, settings);
    $display("The block reported %0d completed handshakes and %0d failures.",
             sb.connects, sb.refusals);
    if (sb.faults == 0 && sb.pending_verdicts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
